[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge once reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/cfpe_pkg.sv]
`default_nettype none

package cfpe_pkg;

    localparam int unsigned ECHO_BYTES = 11;
    localparam int unsigned REPLY_LEN  = ECHO_BYTES + 6;
    localparam int unsigned IDX_W      = $clog2(REPLY_LEN);
    localparam int unsigned CNT_W      = $clog2(ECHO_BYTES + 1);
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [7:0] SOF_BYTE      = 8'hAA;
    localparam logic [7:0] CMD_ECHO      = 8'hE0;
    localparam logic [7:0] MY_ADDR_RST   = 8'h05;
    localparam logic [7:0] HOST_ADDR_RST = 8'hAF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MY_ADDR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HOST_ADDR = 1'b1;

    // positions within the reply frame
    localparam logic [IDX_W-1:0] IDX_SOF        = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_SRC        = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_DST        = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_CMD        = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_LEN        = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_ECHO_FIRST = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_ECHO_LAST  = IDX_W'(ECHO_BYTES + 4);
    localparam logic [IDX_W-1:0] IDX_CSUM       = IDX_W'(REPLY_LEN - 1);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_SRC,
        ST_DEST,
        ST_CMD,
        ST_LEN,
        ST_PAYLOAD,
        ST_CSUM,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic sum_load;      // start sum with header byte
        logic sum_add;
        logic dest_load;
        logic cmd_load;
        logic len_load;
        logic payload_step;  // store payload byte, count down
        logic csum_store;    // checksum byte into echo slot after payload
        logic reply_start;
        logic reply_step;
    } t_cmd;

    typedef struct packed {
        logic is_sof;
        logic src_ok;
        logic left_zero;
        logic left_one;
        logic frame_ok;
        logic reply_last;
    } t_status;

endpackage

`default_nettype wire

[rtl/cfpe_rx_if.sv]
`default_nettype none

interface cfpe_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/cfpe_tx_if.sv]
`default_nettype none

interface cfpe_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_last;

    modport source (output valid, output tx_byte, output tx_last, input ready);
    modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

`default_nettype wire

[rtl/cfpe_ctrl.sv]
`default_nettype none

`include "assert_macros.svh"

module cfpe_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rx_valid,
    output logic                   o_rx_ready,
    output logic                   o_tx_valid,
    input  wire logic              i_tx_ready,
    input  wire cfpe_pkg::t_status i_st,
    output cfpe_pkg::t_cmd         o_cmd
);

    cfpe_pkg::t_state r_state;
    cfpe_pkg::t_state n_state;
    logic             rx_fire;
    logic             tx_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfpe_pkg::ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    assign rx_fire = i_rx_valid && o_rx_ready;
    assign tx_fire = o_tx_valid && i_tx_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_rx_ready = 1'b1;
        o_tx_valid = 1'b0;
        case (r_state)
            cfpe_pkg::ST_HUNT: begin
                if (rx_fire && i_st.is_sof) begin
                    o_cmd.sum_load = 1'b1;
                    n_state        = cfpe_pkg::ST_SRC;
                end
            end
            cfpe_pkg::ST_SRC: begin
                if (rx_fire) begin
                    // a wrong source byte is dropped, not rechecked as a header
                    if (i_st.src_ok) begin
                        o_cmd.sum_add = 1'b1;
                        n_state       = cfpe_pkg::ST_DEST;
                    end else begin
                        n_state = cfpe_pkg::ST_HUNT;
                    end
                end
            end
            cfpe_pkg::ST_DEST: begin
                if (rx_fire) begin
                    o_cmd.sum_add   = 1'b1;
                    o_cmd.dest_load = 1'b1;
                    n_state         = cfpe_pkg::ST_CMD;
                end
            end
            cfpe_pkg::ST_CMD: begin
                if (rx_fire) begin
                    o_cmd.sum_add  = 1'b1;
                    o_cmd.cmd_load = 1'b1;
                    n_state        = cfpe_pkg::ST_LEN;
                end
            end
            cfpe_pkg::ST_LEN: begin
                if (rx_fire) begin
                    o_cmd.sum_add  = 1'b1;
                    o_cmd.len_load = 1'b1;
                    n_state        = cfpe_pkg::ST_PAYLOAD;
                end
            end
            cfpe_pkg::ST_PAYLOAD: begin
                if (rx_fire) begin
                    // zero length: swallow one byte and resync
                    if (i_st.left_zero) begin
                        n_state = cfpe_pkg::ST_HUNT;
                    end else begin
                        o_cmd.sum_add      = 1'b1;
                        o_cmd.payload_step = 1'b1;
                        if (i_st.left_one) begin
                            n_state = cfpe_pkg::ST_CSUM;
                        end
                    end
                end
            end
            cfpe_pkg::ST_CSUM: begin
                if (rx_fire) begin
                    o_cmd.csum_store = 1'b1;
                    if (i_st.frame_ok) begin
                        o_cmd.reply_start = 1'b1;
                        n_state           = cfpe_pkg::ST_REPLY;
                    end else begin
                        n_state = cfpe_pkg::ST_HUNT;
                    end
                end
            end
            cfpe_pkg::ST_REPLY: begin
                o_rx_ready = 1'b0;
                o_tx_valid = 1'b1;
                if (tx_fire) begin
                    // index stays on the checksum slot once the reply is done
                    if (i_st.reply_last) begin
                        n_state = cfpe_pkg::ST_HUNT;
                    end else begin
                        o_cmd.reply_step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = cfpe_pkg::ST_HUNT;
            end
        endcase
    end

    `ASSERT_CLK(a_no_rx_while_tx, !(o_rx_ready && o_tx_valid), "rx taken during reply")
    `ASSERT_CLK(a_reply_ends, (tx_fire && i_st.reply_last) |=> !o_tx_valid,
        "reply continues after last byte")
    `ASSERT_CLK(a_reply_entry, $rose(o_tx_valid) |-> $past(rx_fire && i_st.frame_ok),
        "reply started without a matching frame")

endmodule

`default_nettype wire

[rtl/cfpe_dp.sv]
`default_nettype none

`include "assert_macros.svh"

module cfpe_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [cfpe_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [7:0]                       i_cfg_data,
    input  wire logic [7:0]                       i_rx_byte,
    input  wire cfpe_pkg::t_cmd                   i_cmd,
    output cfpe_pkg::t_status                     o_st,
    output logic [7:0]                            o_tx_byte,
    output logic                                  o_tx_last
);

    logic [7:0]                    r_my_addr;
    logic [7:0]                    r_host_addr;
    logic [7:0]                    r_sum;
    logic [7:0]                    r_dest;
    logic [7:0]                    r_cmd;
    logic [7:0]                    r_left;
    logic [cfpe_pkg::CNT_W-1:0]    r_cnt;
    logic [7:0]                    r_echo [cfpe_pkg::ECHO_BYTES];
    logic [cfpe_pkg::IDX_W-1:0]    r_idx;
    logic [7:0]                    r_tx_sum;
    logic                          slot_free;
    logic [cfpe_pkg::IDX_W-1:0]    echo_off;
    logic [3:0]                    echo_sel;

    // count saturates at the echo depth; beyond it payload bytes are only summed
    assign slot_free = (r_cnt < cfpe_pkg::CNT_W'(cfpe_pkg::ECHO_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_addr   <= cfpe_pkg::MY_ADDR_RST;
            r_host_addr <= cfpe_pkg::HOST_ADDR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cfpe_pkg::REG_MY_ADDR:   r_my_addr   <= i_cfg_data;
                cfpe_pkg::REG_HOST_ADDR: r_host_addr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_dest   <= '0;
            r_cmd    <= '0;
            r_left   <= '0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_tx_sum <= '0;
            for (int i = 0; i < cfpe_pkg::ECHO_BYTES; i++) begin
                r_echo[i] <= '0;
            end
        end else begin
            if (i_cmd.sum_load) begin
                r_sum <= i_rx_byte;
            end else if (i_cmd.sum_add) begin
                r_sum <= r_sum + i_rx_byte;
            end
            if (i_cmd.dest_load) begin
                r_dest <= i_rx_byte;
            end
            if (i_cmd.cmd_load) begin
                r_cmd <= i_rx_byte;
            end
            if (i_cmd.len_load) begin
                r_left <= i_rx_byte;
                r_cnt  <= '0;
            end
            if (i_cmd.payload_step) begin
                r_left <= r_left - 8'd1;
                if (slot_free) begin
                    r_cnt <= r_cnt + cfpe_pkg::CNT_W'(1);
                end
            end
            if ((i_cmd.payload_step || i_cmd.csum_store) && slot_free) begin
                r_echo[r_cnt] <= i_rx_byte;
            end
            if (i_cmd.reply_start) begin
                r_idx    <= '0;
                r_tx_sum <= '0;
            end else if (i_cmd.reply_step) begin
                r_idx    <= r_idx + cfpe_pkg::IDX_W'(1);
                r_tx_sum <= r_tx_sum + o_tx_byte;
            end
        end
    end

    assign o_st.is_sof     = (i_rx_byte == cfpe_pkg::SOF_BYTE);
    assign o_st.src_ok     = (i_rx_byte == r_host_addr);
    assign o_st.left_zero  = (r_left == 8'd0);
    assign o_st.left_one   = (r_left == 8'd1);
    assign o_st.frame_ok   = (i_rx_byte == r_sum) && (r_dest == r_my_addr)
                             && (r_cmd == cfpe_pkg::CMD_ECHO);
    assign o_st.reply_last = (r_idx == cfpe_pkg::IDX_CSUM);

    assign echo_off = r_idx - cfpe_pkg::IDX_ECHO_FIRST;
    assign echo_sel = echo_off[3:0];

    always_comb begin
        case (r_idx)
            cfpe_pkg::IDX_SOF: o_tx_byte = cfpe_pkg::SOF_BYTE;
            cfpe_pkg::IDX_SRC: o_tx_byte = r_my_addr;
            cfpe_pkg::IDX_DST: o_tx_byte = r_host_addr;
            cfpe_pkg::IDX_CMD: o_tx_byte = cfpe_pkg::CMD_ECHO;
            cfpe_pkg::IDX_LEN: o_tx_byte = 8'(cfpe_pkg::ECHO_BYTES);
            default: begin
                if (r_idx inside {[cfpe_pkg::IDX_ECHO_FIRST:cfpe_pkg::IDX_ECHO_LAST]}) begin
                    o_tx_byte = r_echo[echo_sel];
                end else begin
                    o_tx_byte = r_tx_sum;
                end
            end
        endcase
    end

    assign o_tx_last = o_st.reply_last;

    `ASSERT_CLK(a_cnt_bound, r_cnt <= cfpe_pkg::CNT_W'(cfpe_pkg::ECHO_BYTES),
        "echo count past depth")
    `ASSERT_CLK(a_idx_bound, r_idx <= cfpe_pkg::IDX_CSUM, "reply index past frame end")
    `ASSERT_CLK(a_step_left, i_cmd.payload_step |-> (r_left != 8'd0),
        "payload byte taken with none left")

endmodule

`default_nettype wire

[rtl/command_frame_parser_with_echo_reply.sv]
// Input: one byte per cycle while parsing; each byte is handled in the cycle it is taken.
// Reply: the first byte is offered the cycle after the checksum byte is taken; the
// 17 bytes go out at one per cycle at best, paced by output ready; input is held off meanwhile.
// Frame check and echo store use the input byte directly; the reply mux decodes the index.
// Reset (synchronous, active low): parser hunts for a header, sums, counters and the
// echo store clear to zero, addresses return to 0x05 (node) and 0xAF (host).
`default_nettype none

module command_frame_parser_with_echo_reply (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cfpe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]                     i_cfg_data,
    cfpe_rx_if.sink                             i_rx,
    cfpe_tx_if.source                           o_tx
);

    cfpe_pkg::t_cmd    cmd;
    cfpe_pkg::t_status st;

    cfpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (i_rx.ready),
        .o_tx_valid (o_tx.valid),
        .i_tx_ready (o_tx.ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    cfpe_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx_byte  (i_rx.rx_byte),
        .i_cmd      (cmd),
        .o_st       (st),
        .o_tx_byte  (o_tx.tx_byte),
        .o_tx_last  (o_tx.tx_last)
    );

endmodule

`default_nettype wire

[dv/cfpe_reply_checker.sv]
`timescale 1ns / 1ps

module cfpe_reply_checker
    import cfpe_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]           i_cfg_data,
    cfpe_rx_if                        i_rx,
    cfpe_tx_if                        i_tx,
    output int                        o_mismatch_count,
    output int                        o_bytes_due
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } t_reply_byte;

    // own copy of the addresses and the parser state
    logic [7:0] node_addr;
    logic [7:0] host_addr;
    t_state     parse_state;
    logic [7:0] bytes_left;
    logic [7:0] payload_count;
    logic [7:0] running_sum;
    logic [7:0] dest_byte;
    logic [7:0] command_byte;
    logic [7:0] echo_store [ECHO_BYTES];

    t_reply_byte reply_due [$];
    int          mismatches    = 0;
    int          bytes_due_cnt = 0;

    assign o_mismatch_count = mismatches;
    assign o_bytes_due      = bytes_due_cnt;

    // advance the parser by one received byte, queue the echo reply when a frame passes
    function automatic void take_rx_byte(input logic [7:0] b);
        logic [7:0] reply_frame [REPLY_LEN];
        logic [7:0] csum;
        int         k;
        case (parse_state)
            ST_HUNT: begin
                if (b == SOF_BYTE) begin
                    parse_state = ST_SRC;
                    running_sum = b;
                end
            end
            ST_SRC: begin
                if (b == host_addr) begin
                    parse_state = ST_DEST;
                    running_sum = running_sum + b;
                end else begin
                    parse_state = ST_HUNT;
                end
            end
            ST_DEST: begin
                dest_byte   = b;
                running_sum = running_sum + b;
                parse_state = ST_CMD;
            end
            ST_CMD: begin
                command_byte = b;
                running_sum  = running_sum + b;
                parse_state  = ST_LEN;
            end
            ST_LEN: begin
                bytes_left    = b;
                payload_count = 8'd0;
                running_sum   = running_sum + b;
                parse_state   = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                // zero length: this byte is swallowed
                if (bytes_left == 8'd0) begin
                    parse_state = ST_HUNT;
                end else begin
                    bytes_left = bytes_left - 8'd1;
                    if (payload_count < 8'(ECHO_BYTES))
                        echo_store[payload_count] = b;
                    payload_count = payload_count + 8'd1;
                    running_sum   = running_sum + b;
                    if (bytes_left == 8'd0)
                        parse_state = ST_CSUM;
                end
            end
            ST_CSUM: begin
                parse_state = ST_HUNT;
                // short payload: checksum lands in the next echo slot
                if (payload_count < 8'(ECHO_BYTES))
                    echo_store[payload_count] = b;
                if (b == running_sum && dest_byte == node_addr && command_byte == CMD_ECHO) begin
                    reply_frame[IDX_SOF] = SOF_BYTE;
                    reply_frame[IDX_SRC] = node_addr;
                    reply_frame[IDX_DST] = host_addr;
                    reply_frame[IDX_CMD] = CMD_ECHO;
                    reply_frame[IDX_LEN] = 8'(ECHO_BYTES);
                    for (k = 0; k < ECHO_BYTES; k++)
                        reply_frame[int'(IDX_ECHO_FIRST) + k] = echo_store[k];
                    csum = 8'd0;
                    for (k = 0; k < REPLY_LEN - 1; k++)
                        csum = csum + reply_frame[k];
                    reply_frame[IDX_CSUM] = csum;
                    for (k = 0; k < REPLY_LEN; k++)
                        reply_due.push_back('{tx_byte: reply_frame[k],
                                              tx_last: (k == REPLY_LEN - 1)});
                end
            end
            default: begin
                parse_state = ST_HUNT;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_reply_byte due;
        if (!i_rst_n) begin
            node_addr     = MY_ADDR_RST;
            host_addr     = HOST_ADDR_RST;
            parse_state   = ST_HUNT;
            bytes_left    = 8'd0;
            payload_count = 8'd0;
            running_sum   = 8'd0;
            dest_byte     = 8'd0;
            command_byte  = 8'd0;
            for (int k = 0; k < ECHO_BYTES; k++)
                echo_store[k] = 8'd0;
            reply_due.delete();
        end else begin
            // compare before predicting: a reply never starts in the cycle its frame ends
            if (i_tx.valid && i_tx.ready) begin
                if (reply_due.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: unexpected reply byte %02h last %0b",
                                 $realtime, i_tx.tx_byte, i_tx.tx_last);
                    mismatches++;
                end else begin
                    due = reply_due.pop_front();
                    if (i_tx.tx_byte !== due.tx_byte || i_tx.tx_last !== due.tx_last) begin
                        if (mismatches < MAX_REPORTS)
                            $display("%0t: reply mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                     $realtime, due.tx_byte, due.tx_last,
                                     i_tx.tx_byte, i_tx.tx_last);
                        mismatches++;
                    end
                end
            end
            if (i_rx.valid && i_rx.ready)
                take_rx_byte(i_rx.rx_byte);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MY_ADDR:   node_addr = i_cfg_data;
                    REG_HOST_ADDR: host_addr = i_cfg_data;
                    default: ;
                endcase
            end
        end
        bytes_due_cnt = reply_due.size();
    end

endmodule

[dv/tb_command_frame_parser_with_echo_reply.sv]
`timescale 1ns / 1ps

module tb_command_frame_parser_with_echo_reply;
    import cfpe_pkg::*;

    localparam int RST_CYCLES    = 7;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 120;
    localparam int PHASE_BYTES   = 12;

    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_SPARSE} t_rdy_mode;
    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [7:0]           cfg_data;

    cfpe_rx_if rx_bus ();
    cfpe_tx_if tx_bus ();

    int mismatch_count;
    int bytes_due;
    int cycle_count = 0;

    // addresses as last written, used to build frames
    logic [7:0] node_addr;
    logic [7:0] host_addr;

    int        burst_left       = 0;
    int        bytes_sent       = 0;
    int        echo_frames_sent = 0;
    bit        hold_req         = 1'b0;
    int        hold_left        = 0;
    int        seg_left         = 0;
    t_rdy_mode rdy_mode         = RDY_ALWAYS;

    command_frame_parser_with_echo_reply u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_rx       (rx_bus),
        .o_tx       (tx_bus)
    );

    cfpe_reply_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_rx             (rx_bus),
        .i_tx             (tx_bus),
        .o_mismatch_count (mismatch_count),
        .o_bytes_due      (bytes_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // reply side: random stall patterns, plus one long hold-off on request
    initial begin
        tx_bus.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                tx_bus.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    rdy_mode = t_rdy_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(8, 48);
                end
                seg_left--;
                case (rdy_mode)
                    RDY_ALWAYS: tx_bus.ready <= 1'b1;
                    RDY_COIN:   tx_bus.ready <= 1'($urandom_range(0, 1));
                    RDY_MOSTLY: tx_bus.ready <= ($urandom_range(0, 4) != 0);
                    default:    tx_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // one request on the rx channel; bursts with random gaps between them
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                rx_bus.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                              input logic [7:0] cmd, input logic [7:0] len,
                              input t_fill fill, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        sum = SOF_BYTE + src + dst + cmd + len;
        send_byte(SOF_BYTE);
        send_byte(src);
        send_byte(dst);
        send_byte(cmd);
        send_byte(len);
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            sum = sum + b;
            send_byte(b);
        end
        if (bad_sum)
            sum = sum + 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    task automatic send_echo(input logic [7:0] len, input t_fill fill);
        send_frame(host_addr, node_addr, CMD_ECHO, len, fill, 1'b0);
        echo_frames_sent++;
    endtask

    // mostly well-formed echo frames, the rest broken frames and line noise
    task automatic run_random(input int quota);
        int         first_byte;
        int         first_echo;
        int         pick;
        logic [7:0] len;
        first_byte = bytes_sent;
        first_echo = echo_frames_sent;
        while (bytes_sent - first_byte < quota || echo_frames_sent - first_echo < 1) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(12, 40))
                                                : 8'($urandom_range(1, 12));
            if (pick < 60)
                send_echo(len, FILL_RANDOM);
            else if (pick < 68)
                send_frame(host_addr, node_addr, CMD_ECHO, len, FILL_RANDOM, 1'b1);
            else if (pick < 75)
                send_frame(host_addr, node_addr ^ 8'($urandom_range(1, 255)), CMD_ECHO,
                           len, FILL_RANDOM, 1'b0);
            else if (pick < 81)
                send_frame(host_addr, node_addr, CMD_ECHO ^ 8'($urandom_range(1, 255)),
                           len, FILL_RANDOM, 1'b0);
            else if (pick < 86)
                send_frame(host_addr, node_addr, CMD_ECHO, 8'd0, FILL_RANDOM, 1'b0);
            else if (pick < 92) begin
                send_byte(SOF_BYTE);
                send_byte(host_addr ^ 8'($urandom_range(1, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end
    endtask

    // idle the rx side until every reply byte has drained, then let the parser settle
    task automatic settle();
        rx_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (bytes_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_addresses(input logic [7:0] node, input logic [7:0] host);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_MY_ADDR;
        cfg_data <= node;
        @(negedge i_clk);
        cfg_idx  <= REG_HOST_ADDR;
        cfg_data <= host;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        node_addr = node;
        host_addr = host;
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= REG_MY_ADDR;
        cfg_data       <= 8'h00;
        rx_bus.valid   <= 1'b0;
        rx_bus.rx_byte <= 8'h00;
        node_addr = MY_ADDR_RST;
        host_addr = HOST_ADDR_RST;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames at the reset addresses
        send_echo(8'd11, FILL_ZERO);
        send_echo(8'd1, FILL_RANDOM);
        send_echo(8'd12, FILL_RANDOM);
        // header repeated where the source belongs: second byte is eaten
        send_byte(SOF_BYTE);
        send_byte(SOF_BYTE);
        send_echo(8'd3, FILL_RANDOM);
        // zero length swallows the byte after it
        send_frame(host_addr, node_addr, CMD_ECHO, 8'd0, FILL_RANDOM, 1'b0);
        send_echo(8'd2, FILL_RANDOM);
        send_frame(host_addr, node_addr, CMD_ECHO, 8'd2, FILL_RANDOM, 1'b1);
        send_frame(host_addr, node_addr + 8'd1, CMD_ECHO, 8'd2, FILL_RANDOM, 1'b0);
        send_frame(host_addr, node_addr, 8'h00, 8'd2, FILL_ONES, 1'b0);

        settle();
        set_addresses(8'h00, 8'hFF);
        run_random(PHASE_BYTES);

        settle();
        set_addresses(8'hFF, 8'h00);
        run_random(PHASE_BYTES);

        settle();
        set_addresses(8'($urandom), SOF_BYTE);
        run_random(PHASE_BYTES);

        settle();
        set_addresses(8'($urandom), 8'($urandom));
        // long reply stall while frames keep coming back to back
        hold_req   = 1'b1;
        burst_left = 1000;
        repeat (3) send_echo(8'd2, FILL_RANDOM);
        burst_left = 0;
        run_random(PHASE_BYTES);

        settle();
        if (mismatch_count == 0 && bytes_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
